[hw/rtl/branch_target_buffer_tristate_counter_top_assert.svh]
// Assertion macros for the branch target buffer
`ifndef BRANCH_TARGET_BUFFER_TRISTATE_COUNTER_TOP_ASSERT_SVH
`define BRANCH_TARGET_BUFFER_TRISTATE_COUNTER_TOP_ASSERT_SVH

// implication checked every clock outside reset
`define BTB_ASSERT_IMP(label, clk, rst, cond, concl, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (concl)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define BTB_ASSERT_NXT(label, clk, rst, cond, concl, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (concl)) \
      else $error(msg);

`endif

[hw/rtl/btb_tc_pkg.sv]
// ----------------------------------------------------------------------------
// btb_tc_pkg
// Types and codes shared by the branch target buffer modules.
// ----------------------------------------------------------------------------
package btb_tc_pkg;

   localparam logic [1:0] OP_UPDATE = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   localparam logic [1:0] CNT_PLUS  = 2'd1;
   localparam logic [1:0] CNT_ZERO  = 2'd0;
   localparam logic [1:0] CNT_MINUS = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [1:0]  proc_id;
      logic [63:0] branch_addr;
      logic [63:0] target_address;
      logic        taken;
   } req_type;

   typedef struct packed {
      logic        lookup_hit;
      logic        predict_taken;
      logic [63:0] predicted_target;
   } rsp_type;

endpackage

[hw/rtl/btb_tc_queue.sv]
// ----------------------------------------------------------------------------
// btb_tc_queue
// Two-deep queue between the front stage and the table engine.
// ----------------------------------------------------------------------------
module btb_tc_queue
   import btb_tc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output req_type head
);

   req_type    slot_ff [2];
   req_type    slot_in [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ff, rd_in;

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      rd_in      = rd_ff;
      count_in   = count_ff;
      if (push) begin
         slot_in[rd_ff ^ count_ff[0]] = push_data;
      end
      if (pop) begin
         rd_in = ~rd_ff;
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
      end
   end

   assign full      = count_ff[1];
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ff];

endmodule

[hw/rtl/btb_tc_front.sv]
// ----------------------------------------------------------------------------
// btb_tc_front
// Input stage: registers a beat and drops codes that do nothing.
// ----------------------------------------------------------------------------
module btb_tc_front
   import btb_tc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    q_push,
   output req_type q_data,
   input  logic    q_full
);

   logic    hold_ff, hold_in;
   req_type data_ff, data_in;
   logic    keep;

   // the no-op code never enters the queue
   assign keep = req_data.opcode inside {OP_UPDATE, OP_LOOKUP, OP_FLUSH};

   assign q_push    = hold_ff && !q_full;
   assign q_data    = data_ff;
   assign req_stall = hold_ff && q_full;

   always_comb begin
      hold_in = hold_ff;
      data_in = data_ff;
      if (q_push) begin
         hold_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         hold_in = keep;
         data_in = req_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
   end

endmodule

[hw/rtl/btb_tc_engine.sv]
// ----------------------------------------------------------------------------
// btb_tc_engine
// Table engine: match, LRU and counter update, flush, lookup result.
// ----------------------------------------------------------------------------
module btb_tc_engine
   import btb_tc_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  req_type q_head,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int IW = RW;

   typedef enum logic [1:0] {ST_MATCH, ST_APPLY} state_type;

   state_type     state_ff;
   logic          valid_ff [ENTRIES];
   logic [1:0]    owner_ff [ENTRIES];
   logic [63:0]   tag_ff   [ENTRIES];
   logic [63:0]   target_ff[ENTRIES];
   logic [1:0]    cnt_ff   [ENTRIES];
   logic [RW-1:0] rank_ff  [ENTRIES];

   logic [ENTRIES-1:0] hit_ff, own_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [ENTRIES-1:0] hit_vec, own_vec, hit_in, own_in;
   logic               any_hit;
   logic [IW-1:0]      hit_idx, free_idx, lru_idx, slot;
   logic               any_free;
   logic [RW-1:0]      old_rank;
   logic [ENTRIES-1:0] older [ENTRIES];
   logic [RW-1:0]      fresh [ENTRIES];
   logic               out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         own_vec[i] = valid_ff[i] && (owner_ff[i] == q_head.proc_id);
         hit_vec[i] = own_vec[i] && (tag_ff[i] == q_head.branch_addr);
      end
   end

   always_comb begin
      any_hit  = 1'b0;
      hit_idx  = '0;
      any_free = 1'b0;
      free_idx = '0;
      lru_idx  = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit_ff[i]) begin
            any_hit = 1'b1;
            hit_idx = IW'(i);
         end
         if (!valid_ff[i]) begin
            any_free = 1'b1;
            free_idx = IW'(i);
         end
         if (rank_ff[i] == RW'(ENTRIES - 1)) begin
            lru_idx = IW'(i);
         end
      end
      slot     = any_hit ? hit_idx : (any_free ? free_idx : lru_idx);
      old_rank = rank_ff[hit_idx];
   end

   // renumber survivors of a flush; own_ff marks removed entries
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         for (int j = 0; j < ENTRIES; j++) begin
            older[i][j] = valid_ff[j] && !own_ff[j] && (rank_ff[j] < rank_ff[i]);
         end
         fresh[i] = RW'($countones(older[i]));
      end
   end

   assign hit_in = hit_vec;
   assign own_in = own_vec;
   assign q_pop  = (state_ff == ST_APPLY) &&
                   ((q_head.opcode != OP_LOOKUP) || out_free);

   always_ff @(posedge clock) begin
      if (state_ff == ST_MATCH) begin
         hit_ff <= hit_in;
         own_ff <= own_in;
      end
      if (q_pop) begin
         case (q_head.opcode)
            OP_UPDATE: begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (valid_ff[i] && IW'(i) != slot) begin
                     if (any_hit ? (rank_ff[i] < old_rank) : 1'b1) begin
                        rank_ff[i] <= rank_ff[i] + RW'(1);
                     end
                  end
               end
               rank_ff[slot]   <= '0;
               owner_ff[slot]  <= q_head.proc_id;
               tag_ff[slot]    <= q_head.branch_addr;
               target_ff[slot] <= q_head.target_address;
               if (any_hit) begin
                  if (q_head.taken) begin
                     cnt_ff[slot] <= (cnt_ff[slot] == CNT_MINUS) ? CNT_ZERO : CNT_PLUS;
                  end else begin
                     cnt_ff[slot] <= (cnt_ff[slot] == CNT_PLUS) ? CNT_ZERO : CNT_MINUS;
                  end
               end else begin
                  cnt_ff[slot] <= q_head.taken ? CNT_ZERO : CNT_MINUS;
               end
            end
            OP_FLUSH: begin
               for (int i = 0; i < ENTRIES; i++) begin
                  rank_ff[i] <= fresh[i];
               end
            end
            default: begin
            end
         endcase
      end
      if (q_pop && q_head.opcode == OP_LOOKUP) begin
         rsp_ff.lookup_hit       <= any_hit;
         rsp_ff.predict_taken    <= any_hit && (cnt_ff[hit_idx] != CNT_MINUS);
         rsp_ff.predicted_target <= any_hit ? target_ff[hit_idx] : 64'd0;
      end
      if (reset) begin
         state_ff     <= ST_MATCH;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (q_pop && q_head.opcode == OP_LOOKUP) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_MATCH: begin
               if (q_valid) begin
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               if (q_pop) begin
                  state_ff <= ST_MATCH;
               end
            end
            default: begin
               state_ff <= ST_MATCH;
            end
         endcase
         if (q_pop && q_head.opcode == OP_UPDATE) begin
            valid_ff[slot] <= 1'b1;
         end
         if (q_pop && q_head.opcode == OP_FLUSH) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (own_ff[i]) begin
                  valid_ff[i] <= 1'b0;
               end
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hw/rtl/branch_target_buffer_tristate_counter_top.sv]
// ----------------------------------------------------------------------------
// branch_target_buffer_tristate_counter_top
// Shared fully associative BTB with LRU replacement and 3-state counters.
// ----------------------------------------------------------------------------
//   channel | dir | handshake          | payload
//   req     | in  | req_valid/stall    | req_data (req_type)
//   rsp     | out | rsp_valid/stall    | rsp_data (rsp_type), lookups only
//
// The engine registers the associative tag match in ST_MATCH, then in ST_APPLY
// applies the update or flush or forms the result; a lookup waits there while
// its output is stalled. It takes one item at a time. Reset clears all entry
// valid bits at once; no clearing pass. The 2-deep queue lets the input side
// keep taking beats while a lookup result sits stalled in the output register.
module branch_target_buffer_tristate_counter_top
   import btb_tc_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   `include "branch_target_buffer_tristate_counter_top_assert.svh"

   logic    q_push, q_full, q_pop, q_valid;
   req_type q_in, q_head;

   btb_tc_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_push, .q_data(q_in), .q_full
   );

   btb_tc_queue u_queue (
      .clock, .reset, .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .not_empty(q_valid), .head(q_head)
   );

   btb_tc_engine #(.ENTRIES(ENTRIES)) u_engine (
      .clock, .reset, .q_valid, .q_head, .q_pop,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   `BTB_ASSERT_IMP(a_pop_nonempty, clock, reset, q_pop, q_valid, "pop of empty queue")
   `BTB_ASSERT_IMP(a_push_room, clock, reset, q_push, !q_full, "push into full queue")
   `BTB_ASSERT_NXT(a_no_back_pop, clock, reset, q_pop, !q_pop, "pops in adjacent cycles")

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shared branch target buffer: a software table
// with LRU ranks predicts every lookup beat, and the monitor compares results.
// ----------------------------------------------------------------------------
module tb
   import btb_tc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_ENTRIES = 16;
   localparam int STALL_LIMIT = 2000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   branch_target_buffer_tristate_counter_top #(.ENTRIES(NUM_ENTRIES)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // predictor copy of the table
   logic        tbl_valid [NUM_ENTRIES];
   logic [1:0]  tbl_owner [NUM_ENTRIES];
   logic [63:0] tbl_tag   [NUM_ENTRIES];
   logic [63:0] tbl_tgt   [NUM_ENTRIES];
   logic [1:0]  tbl_cnt   [NUM_ENTRIES];
   int          tbl_rank  [NUM_ENTRIES];
   int          tbl_cnt_rank_tmp [NUM_ENTRIES];

   req_type pending_beats[$];
   rsp_type expected_lookups[$];
   int      fail_count = 0;
   bit      stim_done = 1'b0;
   bit      hold_sender = 1'b0;
   int      idle_cycles = 0;

   function automatic int find_slot(logic [1:0] owner, logic [63:0] tag);
      for (int i = 0; i < NUM_ENTRIES; i++)
         if (tbl_valid[i] && tbl_owner[i] == owner && tbl_tag[i] == tag) return i;
      return -1;
   endfunction

   task automatic apply_beat(req_type r);
      int slot;
      int old;
      int cnt;
      rsp_type e;
      slot = find_slot(r.proc_id, r.branch_addr);
      case (r.opcode)
         OP_UPDATE: begin
            if (slot >= 0) begin
               old = tbl_rank[slot];
               for (int i = 0; i < NUM_ENTRIES; i++)
                  if (tbl_valid[i] && tbl_rank[i] < old) tbl_rank[i]++;
               if (r.taken) tbl_cnt[slot] = (tbl_cnt[slot] == CNT_MINUS) ? CNT_ZERO : CNT_PLUS;
               else tbl_cnt[slot] = (tbl_cnt[slot] == CNT_PLUS) ? CNT_ZERO : CNT_MINUS;
            end else begin
               for (int i = 0; i < NUM_ENTRIES && slot < 0; i++)
                  if (!tbl_valid[i]) slot = i;
               if (slot < 0) begin
                  slot = 0;
                  for (int i = 0; i < NUM_ENTRIES; i++)
                     if (tbl_rank[i] > tbl_rank[slot]) slot = i;
                  tbl_valid[slot] = 1'b0;
               end
               for (int i = 0; i < NUM_ENTRIES; i++)
                  if (tbl_valid[i]) tbl_rank[i]++;
               tbl_valid[slot] = 1'b1;
               tbl_cnt[slot] = r.taken ? CNT_ZERO : CNT_MINUS;
            end
            tbl_rank[slot] = 0;
            tbl_owner[slot] = r.proc_id;
            tbl_tag[slot] = r.branch_addr;
            tbl_tgt[slot] = r.target_address;
         end
         OP_LOOKUP: begin
            e = '0;
            if (slot >= 0) begin
               e.lookup_hit = 1'b1;
               e.predict_taken = (tbl_cnt[slot] != CNT_MINUS);
               e.predicted_target = tbl_tgt[slot];
            end
            expected_lookups.push_back(e);
         end
         OP_FLUSH: begin
            for (int i = 0; i < NUM_ENTRIES; i++)
               if (tbl_valid[i] && tbl_owner[i] == r.proc_id) tbl_valid[i] = 1'b0;
            // renumber survivors keeping their order
            for (int i = 0; i < NUM_ENTRIES; i++) begin
               cnt = 0;
               if (tbl_valid[i])
                  for (int j = 0; j < NUM_ENTRIES; j++)
                     if (tbl_valid[j] && tbl_rank[j] < tbl_rank[i]) cnt++;
               tbl_cnt_rank_tmp[i] = cnt;
            end
            for (int i = 0; i < NUM_ENTRIES; i++)
               if (tbl_valid[i]) tbl_rank[i] = tbl_cnt_rank_tmp[i];
         end
         default: ;
      endcase
   endtask

   // small address pool so hits, evictions and cross-processor aliasing happen
   function automatic logic [63:0] pick_addr();
      logic [63:0] a;
      case ($urandom_range(0, 9))
         0: a = {$urandom, $urandom};
         1: a = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
         default: a = 64'h1000 + 4 * $urandom_range(0, 23);
      endcase
      return a;
   endfunction

   function automatic req_type rand_beat();
      req_type r;
      int k;
      k = $urandom_range(0, 99);
      r.opcode = (k < 45) ? OP_UPDATE : (k < 93) ? OP_LOOKUP : (k < 98) ? OP_FLUSH : OP_NOP;
      r.proc_id = 2'($urandom_range(0, 3));
      r.branch_addr = pick_addr();
      r.target_address = {$urandom, $urandom};
      r.taken = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic req_type mk(logic [1:0] op, logic [1:0] pid, logic [63:0] a,
                                  logic [63:0] t, logic tk);
      req_type r;
      r.opcode = op; r.proc_id = pid; r.branch_addr = a; r.target_address = t; r.taken = tk;
      return r;
   endfunction

   initial begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         tbl_valid[i] = 1'b0; tbl_rank[i] = 0;
      end
      // directed: miss, counter saturation both ways, extremes, aliasing, flush, no-op
      pending_beats.push_back(mk(OP_LOOKUP, 2'd0, 64'h0, 64'h0, 1'b0));
      pending_beats.push_back(mk(OP_UPDATE, 2'd0, 64'h0, '1, 1'b1));
      pending_beats.push_back(mk(OP_LOOKUP, 2'd0, 64'h0, 64'h0, 1'b0));
      pending_beats.push_back(mk(OP_UPDATE, 2'd0, 64'h0, 64'h5555, 1'b1));
      pending_beats.push_back(mk(OP_UPDATE, 2'd0, 64'h0, 64'h5555, 1'b1));
      pending_beats.push_back(mk(OP_LOOKUP, 2'd0, 64'h0, 64'h0, 1'b1));
      pending_beats.push_back(mk(OP_UPDATE, 2'd0, 64'h0, 64'hAAAA, 1'b0));
      pending_beats.push_back(mk(OP_UPDATE, 2'd0, 64'h0, 64'hAAAA, 1'b0));
      pending_beats.push_back(mk(OP_UPDATE, 2'd0, 64'h0, 64'hAAAA, 1'b0));
      pending_beats.push_back(mk(OP_LOOKUP, 2'd0, 64'h0, 64'h0, 1'b0));
      pending_beats.push_back(mk(OP_UPDATE, 2'd3, '1, '1, 1'b0));
      pending_beats.push_back(mk(OP_LOOKUP, 2'd3, '1, '1, 1'b1));
      pending_beats.push_back(mk(OP_LOOKUP, 2'd2, '1, 64'h0, 1'b0));
      pending_beats.push_back(mk(OP_NOP, 2'd3, '1, '1, 1'b1));
      pending_beats.push_back(mk(OP_FLUSH, 2'd3, 64'h0, 64'h0, 1'b0));
      pending_beats.push_back(mk(OP_LOOKUP, 2'd3, '1, 64'h0, 1'b0));
      pending_beats.push_back(mk(OP_LOOKUP, 2'd0, 64'h0, 64'h0, 1'b0));
      // overfill to force LRU eviction
      for (int i = 0; i < NUM_ENTRIES + 2; i++)
         pending_beats.push_back(mk(OP_UPDATE, 2'd1, 64'h2000 + i, 64'h9000 + i, i[0]));
      pending_beats.push_back(mk(OP_LOOKUP, 2'd1, 64'h2000, 64'h0, 1'b0));
      pending_beats.push_back(mk(OP_LOOKUP, 2'd1, 64'h2002, 64'h0, 1'b0));
      pending_beats.push_back(mk(OP_LOOKUP, 2'd0, 64'h0, 64'h0, 1'b0));
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int n = 0; n < 800; n++) begin
         if (n == 400) begin
            while (pending_beats.size() != 0 || req_valid) @(negedge clock);
            hold_sender = 1'b1;
            wait (expected_lookups.size() == 0);
            hold_sender = 1'b0;
         end
         pending_beats.push_back(rand_beat());
         if (pending_beats.size() > 4) wait (pending_beats.size() <= 4);
      end
      while (pending_beats.size() != 0 || req_valid) @(negedge clock);
      stim_done = 1'b1;
   end

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_beat(req_data);
         end
         if (req_valid && req_stall) begin
            // hold beat
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0 && !hold_sender) begin
            req_data <= pending_beats.pop_front();
            req_valid <= 1'b1;
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10) * $urandom_range(0, 1);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   int recv_gap = 0;
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_lookups.size() == 0) begin
               $error("unexpected result beat");
               fail_count++;
            end else begin
               e = expected_lookups.pop_front();
               if (rsp_data.lookup_hit !== e.lookup_hit) begin
                  $error("lookup_hit exp %0d got %0d", e.lookup_hit, rsp_data.lookup_hit);
                  fail_count++;
               end
               if (rsp_data.predict_taken !== e.predict_taken) begin
                  $error("predict_taken exp %0d got %0d", e.predict_taken,
                         rsp_data.predict_taken);
                  fail_count++;
               end
               if (rsp_data.predicted_target !== e.predicted_target) begin
                  $error("predicted_target exp %h got %h", e.predicted_target,
                         rsp_data.predicted_target);
                  fail_count++;
               end
            end
            recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
            rsp_stall <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (stim_done && expected_lookups.size() == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && expected_lookups.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end
endmodule
